@@ rtl/itra_pkg.sv @@
// Shared constants, types and helpers for the integer to radix ASCII unit.
// No dependencies; imported by every module of the block.
package itra_pkg;

  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 7;
  localparam int OUT_TDATA_W   = 8;
  localparam int RADIX_W       = 6;
  localparam int WORD_BITS_DEF = 32;
  localparam int STEP_BITS     = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DEC_RADIX   = 6'd10;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h41;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic emit_sign;
    logic emit_digit;
  } itra_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic neg;
    logic cnt_one;
    logic cnt_zero;
    logic out_free;
  } itra_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d < DEC_RADIX) begin
      digit_char = CH_ZERO + dw;
    end else begin
      digit_char = CH_ALPHA + dw - CHAR_W'(DEC_RADIX);
    end
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] w);
    if (w < RADIX_MIN) begin
      clamp_radix = RADIX_MIN;
    end else if (w > RADIX_MAX) begin
      clamp_radix = RADIX_MAX;
    end else begin
      clamp_radix = w;
    end
  endfunction

endpackage

@@ rtl/itra_ctrl.sv @@
// Sequencer for the integer to radix ASCII unit: load, divide, sign, emit.
// Depends on itra_pkg; drives commands into itra_dp.
module itra_ctrl #(
  parameter int NCHUNK = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  itra_pkg::itra_stat_t  stat,
  output itra_pkg::itra_cmd_t   cmd
);
  import itra_pkg::*;

  localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(NCHUNK - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state, state_next;
  logic [CHUNK_W-1:0] chunk, chunk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chunk <= '0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    chunk_next = chunk;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          chunk_next = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (chunk == CHUNK_LAST) begin
          cmd.div_last = 1'b1;
          chunk_next   = '0;
          if (stat.quot_zero) begin
            state_next = stat.neg ? ST_SIGN : ST_EMIT;
          end
        end else begin
          chunk_next = chunk + 1'b1;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.cnt_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_ready = (state == ST_IDLE);

endmodule

@@ rtl/itra_dp.sv @@
// Datapath: radix register, chunked long division, digit stack, output register.
// Depends on itra_pkg; commanded by itra_ctrl.
module itra_dp #(
  parameter int WORD_BITS = itra_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [itra_pkg::RADIX_W-1:0]  cfg_wdata,
  input  logic [itra_pkg::VALUE_W-1:0]  value,
  input  itra_pkg::itra_cmd_t           cmd,
  output itra_pkg::itra_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itra_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);
  import itra_pkg::*;

  localparam int NCHUNK   = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = NCHUNK * STEP_BITS;
  localparam int EXT_W    = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
  localparam int CNT_W    = $clog2(WORD_BITS + 1);

  logic [RADIX_W-1:0]   radix;
  logic [PAD_BITS-1:0]  work, work_next;
  logic [RADIX_W-1:0]   rem, rem_next;
  logic [RADIX_W-1:0]   stk [WORD_BITS];
  logic [CNT_W-1:0]     cnt;
  logic                 neg;

  logic [EXT_W-1:0]     ext;
  logic [WORD_BITS-1:0] v, mag;
  logic                 is_neg;

  assign ext    = EXT_W'(value);
  assign v      = ext[WORD_BITS-1:0];
  assign is_neg = v[WORD_BITS-1] && (radix == DEC_RADIX);
  assign mag    = is_neg ? (~v + 1'b1) : v;

  // STEP_BITS restoring steps per cycle, MSB first
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    logic [STEP_BITS-1:0] q;
    r = rem;
    q = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, work[PAD_BITS-1-i]};
      if (t >= {1'b0, radix}) begin
        t = t - {1'b0, radix};
        q[STEP_BITS-1-i] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    rem_next  = r;
    work_next = (work << STEP_BITS) | PAD_BITS'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wen) begin
      radix <= clamp_radix(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= PAD_BITS'(mag);
      rem  <= '0;
      neg  <= is_neg;
    end else if (cmd.div_step) begin
      work <= work_next;
      rem  <= cmd.div_last ? '0 : rem_next;
    end
  end

  // digit stack: push at the top on each finished digit, pop on emit
  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_last) begin
      stk[0] <= rem_next;
      for (int i = 1; i < WORD_BITS; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (cmd.emit_digit) begin
      for (int i = 0; i < WORD_BITS - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_step && cmd.div_last) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.emit_digit) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char <= CH_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char <= digit_char(stk[0]);
      out_last <= (cnt == CNT_W'(1));
    end
  end

  assign stat.quot_zero = (work_next == '0);
  assign stat.neg       = neg;
  assign stat.cnt_one   = (cnt == CNT_W'(1));
  assign stat.cnt_zero  = (cnt == '0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

@@ rtl/integer_to_radix_ascii_unit.sv @@
// Top level of the integer to radix ASCII unit.
// Depends on itra_pkg, itra_ctrl and itra_dp.
//
// Converts an integer into its text form in a programmable radix.
// Input stream s_axis: one value per transfer. Output stream m_axis: one
// ASCII character per transfer, most significant digit first, tlast on the
// final character. cfg_wen/cfg_wdata write the radix (clamped to 2..36);
// write only while the unit is idle. Radix 10 negative values get a '-'.
// Each digit takes NCHUNK chunks of division (WORD_BITS/8 rounded up,
// 4 for 32 bits), run by the 8-bit-per-cycle divide step against the
// radix. Emission then pops one character per cycle from the digit
// stack while the output register is free. One item is converted
// at a time; s_axis_tready is high only while the sequencer is idle.
// The last character may still sit in the output register while the next
// value is taken. A stall on m_axis_tready holds the character and pauses
// emission. Reset (rst, synchronous) sets radix to 10 and empties the unit.
module integer_to_radix_ascii_unit #(
  parameter int WORD_BITS = itra_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [itra_pkg::RADIX_W-1:0]      cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [itra_pkg::VALUE_W-1:0]      s_axis_tdata,   // [31:0] value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [itra_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [6:0] character, [7] zero
  output logic                              m_axis_tlast
);
  import itra_pkg::*;

  localparam int NCHUNK = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;

  itra_cmd_t          cmd;
  itra_stat_t         stat;
  logic [CHAR_W-1:0]  out_char;

  itra_ctrl #(
    .NCHUNK (NCHUNK)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  itra_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .value     (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_char);

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> stat.cnt_zero)
    else $error("digit stack not empty while idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new transfer taken while converting");

  a_last_not_sign: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_char != CH_MINUS))
    else $error("sign marked as final character");

endmodule
